// ===== design/hall_angle_event_scheduler_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef HALL_ANGLE_EVENT_SCHEDULER_MACROS_SVH
`define HALL_ANGLE_EVENT_SCHEDULER_MACROS_SVH

// Implication checked on every clock edge, disabled in reset.
`define HAES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define HAES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/haes_pkg.sv =====
// ----------------------------------------------------------------------------
// haes_pkg
// Shared types, constants and codes of the hall angle event scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package haes_pkg;

    localparam int POINTS     = 8;
    localparam int IDX_W      = $clog2(POINTS);
    localparam int CNT_W      = $clog2(POINTS + 1);
    localparam int TURN_UNITS = 5760;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SORT = 3'd1;
    localparam logic [2:0] OP_HALL = 3'd2;
    localparam logic [2:0] OP_CMP  = 3'd3;
    localparam logic [2:0] OP_TICK = 3'd4;

    localparam logic [2:0] KIND_ADD_OK   = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_SET_CMP  = 3'd2;
    localparam logic [2:0] KIND_PHASE    = 3'd3;
    localparam logic [2:0] KIND_SYNC     = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd5;

    localparam logic [1:0] REG_OFFSET  = 2'd0;
    localparam logic [1:0] REG_PHASES  = 2'd1;
    localparam logic [1:0] REG_ENABLE  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_SORT_OUTER,
        ST_SORT_INNER,
        ST_SORT_SWAP,
        ST_HALL_BEGIN,
        ST_HALL_MUL,
        ST_HALL_DIV,
        ST_HALL_STORE,
        ST_EMIT
    } haes_state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_item;
        logic add_scan;
        logic add_write;
        logic sort_begin_outer;
        logic sort_step_inner;
        logic sort_swap;
        logic sort_next_outer;
        logic hall_begin;
        logic hall_mul;
        logic div_start;
        logic hall_store;
        logic cmp_step;
        logic tick_step;
        logic emit_pop;
    } haes_cmd_t;

    // Datapath status back to the controller.
    typedef struct packed {
        logic       scan_done;
        logic       inner_done;
        logic       outer_done;
        logic       div_busy;
        logic       hall_done;
        logic [1:0] res_count;
    } haes_status_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] compare_value;
        logic [31:0] point_name_out;
        logic [39:0] sync_value;
        logic        last;
    } haes_result_t;

endpackage
`default_nettype wire

// ===== design/haes_if.sv =====
// ----------------------------------------------------------------------------
// haes channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface haes_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] capture_count;
    logic [12:0] point_angle;
    logic [31:0] point_name_in;
    modport source (output valid, operation, capture_count, point_angle, point_name_in,
                    input ready);
    modport sink (input valid, operation, capture_count, point_angle, point_name_in,
                  output ready);
endinterface

interface haes_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] compare_value;
    logic [31:0] point_name_out;
    logic [39:0] sync_value;
    logic        last;
    modport source (output valid, kind, compare_value, point_name_out, sync_value, last,
                    input ready);
    modport sink (input valid, kind, compare_value, point_name_out, sync_value, last,
                  output ready);
endinterface

interface haes_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/haes_divider.sv =====
// ----------------------------------------------------------------------------
// haes_divider
// Divide by the turn constant: shift out 2^7, then a reciprocal multiply by
// 1/45 built from four 20x20 partial products, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module haes_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [45:0] dividend,
    output logic             busy,
    output logic [31:0]      quotient
);
    import haes_pkg::*;

    // 5760 = 128 * 45; x = dividend >> 7 fits in 39 bits.
    localparam int          PRE_SHIFT = 7;
    localparam int          SHIFT     = 45;
    localparam logic [63:0] ODD_DIV   = 64'(TURN_UNITS >> PRE_SHIFT);
    // ceil(2^45 / 45): exact floor for every 39-bit x.
    localparam logic [39:0] RECIP     =
        40'(((64'd1 << SHIFT) + ODD_DIV - 64'd1) / ODD_DIV);

    logic [38:0] x_reg;
    logic [79:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic [19:0] pp_a;
    logic [19:0] pp_b;
    logic [39:0] pp;
    logic [79:0] pp_shifted;

    assign pp_a = step_reg[1] ? {1'b0, x_reg[38:20]} : x_reg[19:0];
    assign pp_b = step_reg[0] ? RECIP[39:20] : RECIP[19:0];
    assign pp   = 40'(pp_a) * 40'(pp_b);

    always_comb
    begin
        case (step_reg)
            2'd0:    pp_shifted = 80'(pp);
            2'd3:    pp_shifted = {pp, 40'd0};
            default: pp_shifted = {20'd0, pp, 20'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= dividend[45:PRE_SHIFT];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_shifted;
    end

    assign busy     = busy_reg;
    assign quotient = acc_reg[SHIFT+31:SHIFT];
endmodule
`default_nettype wire

// ===== design/haes_datapath.sv =====
// ----------------------------------------------------------------------------
// haes_datapath
// Point tables, timing registers, sort and scan indexes, result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hall_angle_event_scheduler_macros.svh"
module haes_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire haes_pkg::haes_cmd_t    cmd,
    output haes_pkg::haes_status_t      status,
    input  wire logic [31:0]            capture_count,
    input  wire logic [12:0]            point_angle,
    input  wire logic [31:0]            point_name_in,
    input  wire logic [12:0]            offset_angle,
    input  wire logic [7:0]             phases_count,
    input  wire logic                   enable,
    input  wire logic [15:0]            timeout_ticks,
    output haes_pkg::haes_result_t      head
);
    import haes_pkg::*;

    logic [12:0] angle_reg   [POINTS];
    logic [31:0] name_reg    [POINTS];
    logic [31:0] compare_reg [POINTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] search_reg;
    logic [31:0] period_reg;
    logic [31:0] last_cap_reg;
    logic [15:0] idle_reg;

    logic [31:0] cap_reg;
    logic [12:0] ang_in_reg;
    logic [31:0] name_in_reg;

    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] best_reg;
    logic             found_reg;
    logic [45:0]      prod_reg;

    haes_result_t res_reg [2];
    logic [1:0]   res_cnt_reg;

    logic [IDX_W-1:0] i_ix, j_ix, b_ix;
    logic [13:0] ang_sum;
    logic        div_busy;
    logic [31:0] quotient;
    logic [31:0] new_period;
    logic [15:0] idle_inc;
    logic        name_hit;

    assign i_ix = i_reg[IDX_W-1:0];
    assign j_ix = j_reg[IDX_W-1:0];
    assign b_ix = best_reg[IDX_W-1:0];
    assign ang_sum = {1'b0, angle_reg[i_ix]} + {1'b0, offset_angle};
    assign new_period = cap_reg - last_cap_reg;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    // Match only among live entries.
    assign name_hit = (i_reg < count_reg) && (name_reg[i_ix] == name_in_reg);

    haes_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    function automatic haes_result_t mk(input logic [2:0] k, input logic [31:0] c,
                                        input logic [31:0] n, input logic [39:0] s,
                                        input logic l);
        haes_result_t r;
        r.kind = k;
        r.compare_value = c;
        r.point_name_out = n;
        r.sync_value = s;
        r.last = l;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cap_reg     <= capture_count;
            ang_in_reg  <= point_angle;
            name_in_reg <= point_name_in;
        end
        if (cmd.hall_mul)
            prod_reg <= 46'(ang_sum) * 46'(period_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < POINTS; k++)
            begin
                angle_reg[k]   <= '0;
                name_reg[k]    <= '0;
                compare_reg[k] <= '0;
            end
            count_reg    <= '0;
            search_reg   <= '0;
            period_reg   <= '0;
            last_cap_reg <= '0;
            idle_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            best_reg     <= '0;
            found_reg    <= 1'b0;
            res_reg[0]   <= '0;
            res_reg[1]   <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                i_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.add_scan)
            begin
                if (name_hit)
                    found_reg <= 1'b1;
                else
                    i_reg <= i_reg + 1'b1;
            end
            if (cmd.add_write)
            begin
                if (found_reg || name_hit || count_reg < CNT_W'(POINTS))
                begin
                    angle_reg[i_ix]   <= ang_in_reg;
                    name_reg[i_ix]    <= name_in_reg;
                    compare_reg[i_ix] <= '0;
                    if (!(found_reg || name_hit))
                        count_reg <= count_reg + 1'b1;
                    res_reg[0] <= mk(KIND_ADD_OK, '0, '0, '0, 1'b1);
                end
                else
                    res_reg[0] <= mk(KIND_FULL, '0, '0, '0, 1'b1);
                res_cnt_reg <= 2'd1;
            end
            if (cmd.sort_begin_outer)
            begin
                best_reg <= i_reg;
                j_reg    <= i_reg + 1'b1;
            end
            if (cmd.sort_step_inner)
            begin
                if (angle_reg[j_ix] < angle_reg[b_ix])
                    best_reg <= j_reg;
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.sort_swap && best_reg != i_reg)
            begin
                angle_reg[i_ix]   <= angle_reg[b_ix];
                angle_reg[b_ix]   <= angle_reg[i_ix];
                name_reg[i_ix]    <= name_reg[b_ix];
                name_reg[b_ix]    <= name_reg[i_ix];
                compare_reg[i_ix] <= compare_reg[b_ix];
                compare_reg[b_ix] <= compare_reg[i_ix];
            end
            if (cmd.sort_next_outer)
                i_reg <= i_reg + 1'b1;
            if (cmd.hall_begin)
            begin
                period_reg   <= new_period;
                last_cap_reg <= cap_reg;
                idle_reg     <= '0;
            end
            if (cmd.hall_store)
            begin
                compare_reg[i_ix] <= quotient + cap_reg;
                i_reg <= i_reg + 1'b1;
                if (i_reg + 1'b1 >= count_reg)
                begin
                    if (count_reg != '0)
                    begin
                        search_reg <= '0;
                        res_reg[0] <= mk(KIND_SET_CMP,
                            (i_reg == '0) ? quotient + cap_reg : compare_reg[0],
                            '0, '0, 1'b0);
                        res_reg[1] <= mk(KIND_SYNC, '0, '0,
                            40'(period_reg) * 40'(phases_count), 1'b1);
                        res_cnt_reg <= 2'd2;
                    end
                end
            end
            if (cmd.hall_begin && count_reg == '0)
            begin
                res_reg[0]  <= mk(KIND_SYNC, '0, '0,
                                  40'(new_period) * 40'(phases_count), 1'b1);
                res_cnt_reg <= 2'd1;
            end
            if (cmd.cmp_step && enable && count_reg != '0 && search_reg < count_reg)
            begin
                search_reg <= search_reg + 1'b1;
                if (search_reg + 1'b1 < count_reg)
                begin
                    res_reg[0] <= mk(KIND_SET_CMP,
                        compare_reg[IDX_W'(search_reg + 1'b1)], '0, '0, 1'b0);
                    res_reg[1] <= mk(KIND_PHASE, '0,
                        name_reg[search_reg[IDX_W-1:0]], '0, 1'b1);
                    res_cnt_reg <= 2'd2;
                end
                else
                begin
                    res_reg[0] <= mk(KIND_PHASE, '0,
                        name_reg[search_reg[IDX_W-1:0]], '0, 1'b1);
                    res_cnt_reg <= 2'd1;
                end
            end
            if (cmd.tick_step)
            begin
                if (idle_inc >= timeout_ticks)
                begin
                    idle_reg    <= '0;
                    period_reg  <= '0;
                    res_reg[0]  <= mk(KIND_TIMEOUT, '0, '0, '0, 1'b1);
                    res_cnt_reg <= 2'd1;
                end
                else
                    idle_reg <= idle_inc;
            end
            if (cmd.emit_pop)
            begin
                res_reg[0]  <= res_reg[1];
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

    assign head = res_reg[0];
    assign status.scan_done  = found_reg || (i_reg >= count_reg) || name_hit;
    assign status.inner_done = (j_reg >= count_reg);
    assign status.outer_done = (i_reg + 1'b1 >= count_reg) || (count_reg == '0);
    assign status.div_busy   = div_busy;
    assign status.hall_done  = (i_reg >= count_reg);
    assign status.res_count  = res_cnt_reg;

    `HAES_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(POINTS),
        "point count beyond table depth")
    `HAES_ASSERT_IMPL(a_search_range, clk, rst_n, 1'b1, search_reg <= count_reg,
        "search index beyond point count")
    `HAES_ASSERT_NEXT(a_pop, clk, rst_n, cmd.emit_pop && res_cnt_reg == 2'd2,
        res_cnt_reg == 2'd1, "result queue pop lost an entry")
endmodule
`default_nettype wire

// ===== design/haes_controller.sv =====
// ----------------------------------------------------------------------------
// haes_controller
// Sequencer for add scan, selection sort, hall recompute and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hall_angle_event_scheduler_macros.svh"
module haes_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [2:0]            operation,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire haes_pkg::haes_status_t status,
    output haes_pkg::haes_cmd_t        cmd
);
    import haes_pkg::*;

    haes_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (operation)
                        OP_ADD:  state_next = ST_ADD_SCAN;
                        OP_SORT: state_next = ST_SORT_OUTER;
                        OP_HALL: state_next = ST_HALL_BEGIN;
                        OP_CMP:
                        begin
                            cmd.cmp_step = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_TICK:
                        begin
                            cmd.tick_step = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.add_write = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                    cmd.add_scan = 1'b1;
            end
            ST_SORT_OUTER:
            begin
                if (status.outer_done)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.sort_begin_outer = 1'b1;
                    state_next = ST_SORT_INNER;
                end
            end
            ST_SORT_INNER:
            begin
                if (status.inner_done)
                    state_next = ST_SORT_SWAP;
                else
                    cmd.sort_step_inner = 1'b1;
            end
            ST_SORT_SWAP:
            begin
                cmd.sort_swap       = 1'b1;
                cmd.sort_next_outer = 1'b1;
                state_next = ST_SORT_OUTER;
            end
            ST_HALL_BEGIN:
            begin
                // Latch period first; an empty table goes straight to delivery.
                cmd.hall_begin = 1'b1;
                if (status.hall_done)
                    state_next = ST_EMIT;
                else
                    state_next = ST_HALL_MUL;
            end
            ST_HALL_MUL:
            begin
                cmd.hall_mul = 1'b1;
                state_next = ST_HALL_DIV;
            end
            ST_HALL_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_HALL_STORE;
            end
            ST_HALL_STORE:
            begin
                if (!status.div_busy)
                begin
                    cmd.hall_store = 1'b1;
                    if (status.outer_done)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_HALL_MUL;
                end
            end
            ST_EMIT:
            begin
                out_valid = (status.res_count != 2'd0);
                if (status.res_count == 2'd0)
                    state_next = ST_IDLE;
                else if (out_ready)
                begin
                    cmd.emit_pop = 1'b1;
                    if (status.res_count == 2'd1)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `HAES_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE,
        "input taken outside idle")
    `HAES_ASSERT_IMPL(a_valid_emit, clk, rst_n, out_valid, state_reg == ST_EMIT,
        "result shown outside emit")
    `HAES_ASSERT_NEXT(a_pop_last, clk, rst_n,
        cmd.emit_pop && status.res_count == 2'd1, state_reg == ST_IDLE,
        "controller stayed busy after last result")
endmodule
`default_nettype wire

// ===== design/hall_angle_event_scheduler.sv =====
// Hall angle event scheduler. Holds up to POINTS named angle points and turns
// them into timer compare times on each hall edge, then steps through them on
// compare matches. One item is handled at a time; the next item is taken once
// every result of the previous one has been delivered. An add scans one table
// entry per cycle; a sort orders the table by ascending angle; a hall edge
// latches the period, then runs each point through a registered multiply and
// a four-step reciprocal divide by 5760. Compare match and tick update state
// at the accept edge, and their results, if any, are offered in the following cycle.
// Results leave one per cycle while out.ready is high.
// ----------------------------------------------------------------------------
// hall_angle_event_scheduler
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hall_angle_event_scheduler (
    input  wire logic    clk,
    input  wire logic    rst_n,
    haes_in_if.sink      in,
    haes_out_if.source   out,
    haes_cfg_if.sink     cfg
);
    import haes_pkg::*;

    logic [12:0] offset_reg;
    logic [7:0]  phases_reg;
    logic        enable_reg;
    logic [15:0] timeout_reg;

    haes_cmd_t    cmd;
    haes_status_t status;
    haes_result_t head;

    // Configuration writes are always accepted; unknown indexes drop.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            phases_reg  <= 8'd1;
            enable_reg  <= 1'b0;
            timeout_reg <= 16'd1000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OFFSET:  offset_reg  <= cfg.data[12:0];
                REG_PHASES:  phases_reg  <= cfg.data[7:0];
                REG_ENABLE:  enable_reg  <= cfg.data[0];
                REG_TIMEOUT: timeout_reg <= cfg.data;
                default:     ;
            endcase
        end
    end

    haes_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .operation (in.operation),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    haes_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .capture_count (in.capture_count),
        .point_angle   (in.point_angle),
        .point_name_in (in.point_name_in),
        .offset_angle  (offset_reg),
        .phases_count  (phases_reg),
        .enable        (enable_reg),
        .timeout_ticks (timeout_reg),
        .head          (head)
    );

    assign out.kind           = head.kind;
    assign out.compare_value  = head.compare_value;
    assign out.point_name_out = head.point_name_out;
    assign out.sync_value     = head.sync_value;
    assign out.last           = head.last;
endmodule
`default_nettype wire
